### hw/rtl/dat_pkg.sv
`timescale 1ns / 1ps
// Package for the affine transform decomposition unit: pipeline stage numbers,
// payload types and the step functions of the root and divider pipelines.
// It depends on nothing else.
package dat_pkg;

    localparam int ST_M    = 1;
    localparam int ST_PROD = 2;
    localparam int ST_COF  = 3;
    localparam int ST_PP   = 4;
    localparam int ST_TERM = 5;
    localparam int ST_DET  = 6;
    localparam int SQ_STEPS  = 32;
    localparam int DIVA_BITS = 62;
    localparam int DIVB_BITS = 31;
    localparam int ST_LEN = ST_COF + SQ_STEPS;
    localparam int ST_DA0 = ST_LEN + 1;
    localparam int ST_QA  = ST_DA0 + DIVA_BITS;
    localparam int ST_R   = ST_QA + 1;
    localparam int ST_TR  = ST_R + 1;
    localparam int ST_SB0 = ST_TR + 1;
    localparam int ST_S   = ST_SB0 + SQ_STEPS;
    localparam int ST_DB0 = ST_S + 1;
    localparam int ST_QB  = ST_DB0 + DIVB_BITS;

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    localparam logic [1:0] BR_X = 2'd0;
    localparam logic [1:0] BR_Y = 2'd1;
    localparam logic [1:0] BR_Z = 2'd2;
    localparam logic [1:0] BR_W = 2'd3;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] r;
    } t_sqrt;

    typedef struct packed {
        logic [31:0] rem;
        logic        q;
    } t_div_bit;

    typedef struct packed {
        logic [31:0] rem;
        logic [61:0] dq;
    } t_diva;

    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] dq;
        logic        sat;
    } t_divb;

    typedef struct packed {
        logic [31:0]       uniform_scale;
        logic [3:0][31:0]  rot;
        logic [2:0][31:0]  move;
        logic              degenerate;
    } t_result;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic t_sqrt sqrt_step(input t_sqrt a, input int k);
        logic [63:0] b;
        t_sqrt       o;
        b = 64'd1 << (62 - 2 * k);
        if (a.x >= a.r + b) begin
            o.x = a.x - (a.r + b);
            o.r = (a.r >> 1) + b;
        end else begin
            o.x = a.x;
            o.r = a.r >> 1;
        end
        return o;
    endfunction

    function automatic t_div_bit div_bit(input logic [31:0] rem, input logic nb,
                                         input logic [31:0] d);
        logic [32:0] t;
        t_div_bit    o;
        t = {rem, nb};
        if (t >= {1'b0, d}) begin
            o.rem = 32'(t - {1'b0, d});
            o.q   = 1'b1;
        end else begin
            o.rem = t[31:0];
            o.q   = 1'b0;
        end
        return o;
    endfunction

    function automatic t_diva diva_step(input t_diva a, input logic [31:0] d);
        t_div_bit b;
        t_diva    o;
        b     = div_bit(a.rem, a.dq[61], d);
        o.rem = b.rem;
        o.dq  = {a.dq[60:0], b.q};
        return o;
    endfunction

    function automatic t_divb divb_init(input logic signed [63:0] x, input logic [31:0] s);
        logic [63:0] mag;
        logic [63:0] d;
        t_divb       o;
        mag   = x[63] ? 64'(-x) : 64'(x);
        d     = {mag[34:0], 29'd0};
        o.sat = d[63:31] >= {1'b0, s};
        o.rem = d[62:31];
        o.dq  = d[30:0];
        return o;
    endfunction

    function automatic t_divb divb_step(input t_divb a, input logic [31:0] d);
        t_div_bit b;
        t_divb    o;
        b     = div_bit(a.rem, a.dq[30], d);
        o.rem = b.rem;
        o.dq  = {a.dq[29:0], b.q};
        o.sat = a.sat;
        return o;
    endfunction

    function automatic logic [30:0] main_of(input logic [31:0] s);
        return (s[31:1] > ONE_Q30[30:0]) ? ONE_Q30[30:0] : s[31:1];
    endfunction

    function automatic logic signed [96:0] det_term(input logic signed [64:0] ph,
                                                     input logic signed [64:0] pl);
        logic signed [96:0] a;
        a = 97'(ph);
        a = a <<< 32;
        return a + 97'(pl);
    endfunction

    function automatic logic det_negative(input logic signed [96:0] t0,
                                          input logic signed [96:0] t1,
                                          input logic signed [96:0] t2);
        logic signed [98:0] d;
        d = 99'(t0) - 99'(t1) + 99'(t2);
        return d[98];
    endfunction

endpackage

### hw/rtl/decompose_affine_transform_unit.sv
`timescale 1ns / 1ps
// Top level of the affine transform decomposition unit: a single deep pipeline
// with an output register and one skid word. It depends on dat_pkg.
//
// Usage. The input channel (i_in_valid, o_in_ready) moves one word per
// transform: the three basis rows and the translation row, Q16.16. The output
// channel (o_out_valid, i_out_ready) moves one word per transform: the signed
// length of the first row as scale, the rotation quaternion in Q2.30, the
// translation unchanged and a flag that marks a non-positive trace term.
// One word can be accepted every cycle while o_in_ready is high. The pipeline
// holds two 32-step root pipelines, the 62-step divider for the normalised rows
// and the 31-step divider for the quaternion components, each one bit per
// stage.
// Reset clears every valid bit; data registers keep whatever they held.
// When the receiver stalls, the pipeline keeps moving until a second finished
// word sits in the skid register; then o_in_ready falls and the whole pipeline
// holds until the output word is taken.
module decompose_affine_transform_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_basis0_x,
    input  logic signed [31:0] i_basis0_y,
    input  logic signed [31:0] i_basis0_z,
    input  logic signed [31:0] i_basis1_x,
    input  logic signed [31:0] i_basis1_y,
    input  logic signed [31:0] i_basis1_z,
    input  logic signed [31:0] i_basis2_x,
    input  logic signed [31:0] i_basis2_y,
    input  logic signed [31:0] i_basis2_z,
    input  logic signed [31:0] i_offset_x,
    input  logic signed [31:0] i_offset_y,
    input  logic signed [31:0] i_offset_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_uniform_scale,
    output logic signed [31:0] o_rot_x,
    output logic signed [31:0] o_rot_y,
    output logic signed [31:0] o_rot_z,
    output logic signed [31:0] o_rot_w,
    output logic signed [31:0] o_move_x,
    output logic signed [31:0] o_move_y,
    output logic signed [31:0] o_move_z,
    output logic               o_degenerate
);

    localparam int VW = (VALUE_WIDTH > 32) ? 32 : ((VALUE_WIDTH < 2) ? 2 : VALUE_WIDTH);
    localparam int SH = 32 - VW;
    localparam logic signed [33:0] SMAX = (34'sd1 <<< (VW - 1)) - 34'sd1;
    localparam logic signed [33:0] SMIN = -SMAX - 34'sd1;

    localparam int ST_COF = dat_pkg::ST_COF;
    localparam int ST_DET = dat_pkg::ST_DET;
    localparam int ST_LEN = dat_pkg::ST_LEN;
    localparam int ST_DA0 = dat_pkg::ST_DA0;
    localparam int ST_QA  = dat_pkg::ST_QA;
    localparam int ST_TR  = dat_pkg::ST_TR;
    localparam int ST_SB0 = dat_pkg::ST_SB0;
    localparam int ST_S   = dat_pkg::ST_S;
    localparam int ST_DB0 = dat_pkg::ST_DB0;
    localparam int ST_QB  = dat_pkg::ST_QB;

    function automatic logic signed [31:0] sext_val(input logic [31:0] v);
        logic signed [31:0] tmp;
        tmp = $signed(v << SH);
        return tmp >>> SH;
    endfunction

    function automatic logic [31:0] scale_of(input logic [31:0] len, input logic neg);
        logic signed [33:0] v;
        v = $signed({2'b00, len});
        if (neg) begin
            v = -v;
        end
        if (v > SMAX) begin
            v = SMAX;
        end else if (v < SMIN) begin
            v = SMIN;
        end
        return v[31:0];
    endfunction

    logic                 w_en;
    logic [31:0]          w_in [12];
    logic [ST_QB:1]       r_vld;

    logic signed [31:0]   r_m [1:ST_LEN][9];
    logic signed [31:0]   r_t [1:ST_QB][3];
    logic [63:0]          r_p_sq [9];
    logic signed [63:0]   r_p_cf [6];
    logic signed [64:0]   r_cof [3];
    logic signed [64:0]   r_pl [3];
    logic signed [64:0]   r_ph [3];
    logic signed [96:0]   r_term [3];
    logic                 r_neg [ST_DET:ST_LEN];

    dat_pkg::t_sqrt       r_sa [ST_COF:ST_LEN][3];
    dat_pkg::t_diva       r_da [ST_DA0:ST_QA][9];
    logic [31:0]          r_da_len [ST_DA0:ST_QA][3];
    logic                 r_da_neg [ST_DA0:ST_QA][9];
    logic [31:0]          r_scale [ST_DA0:ST_QB];

    logic signed [63:0]   r_rm [9];
    logic signed [63:0]   r_tr;
    logic [1:0]           r_qc [ST_TR:ST_QB];
    logic signed [63:0]   r_x [ST_TR:ST_S][3];
    logic                 r_pos [ST_SB0:ST_QB];
    dat_pkg::t_sqrt       r_sb [ST_SB0:ST_S];

    dat_pkg::t_divb       r_db [ST_DB0:ST_QB][3];
    logic                 r_db_neg [ST_DB0:ST_QB][3];
    logic [31:0]          r_db_s [ST_DB0:ST_QB];
    logic [30:0]          r_main [ST_DB0:ST_QB];

    logic [1:0]           w_qc;
    logic                 w_s1n;
    logic                 w_s2n;
    logic                 w_s3n;
    logic signed [63:0]   w_tr;
    logic signed [63:0]   w_x [3];
    logic [3:0][31:0]     w_rot;
    logic [31:0]          w_cmp [3];
    dat_pkg::t_result     w_res;

    logic                 r_out_vld;
    logic                 r_sk_vld;
    dat_pkg::t_result     r_out;
    dat_pkg::t_result     r_sk;

    assign w_in[0]  = i_basis0_x;
    assign w_in[1]  = i_basis0_y;
    assign w_in[2]  = i_basis0_z;
    assign w_in[3]  = i_basis1_x;
    assign w_in[4]  = i_basis1_y;
    assign w_in[5]  = i_basis1_z;
    assign w_in[6]  = i_basis2_x;
    assign w_in[7]  = i_basis2_y;
    assign w_in[8]  = i_basis2_z;
    assign w_in[9]  = i_offset_x;
    assign w_in[10] = i_offset_y;
    assign w_in[11] = i_offset_z;

    assign w_en       = !r_sk_vld;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[ST_QB-1:1], i_in_valid};
        end
    end

    // Branch choice, trace term and the three side sums from the rotation matrix.
    always_comb begin
        if (r_rm[8] < 0) begin
            w_qc = (r_rm[0] > r_rm[4]) ? dat_pkg::BR_X : dat_pkg::BR_Y;
        end else begin
            w_qc = (r_rm[0] < -r_rm[4]) ? dat_pkg::BR_Z : dat_pkg::BR_W;
        end
        w_s1n = w_qc[1];
        w_s2n = w_qc[0];
        w_s3n = (w_qc == dat_pkg::BR_X) || (w_qc == dat_pkg::BR_W);
        w_tr  = 64'sd1073741824 + (w_s3n ? r_rm[0] : -r_rm[0])
                + (w_s2n ? r_rm[4] : -r_rm[4]) + (w_s1n ? r_rm[8] : -r_rm[8]);
        w_x[0] = r_rm[1] + (w_s1n ? -r_rm[3] : r_rm[3]);
        w_x[1] = r_rm[6] + (w_s2n ? -r_rm[2] : r_rm[2]);
        w_x[2] = r_rm[5] + (w_s3n ? -r_rm[7] : r_rm[7]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int e = 0; e < 9; e++) begin
                r_m[1][e] <= sext_val(w_in[e]);
            end
            for (int e = 0; e < 3; e++) begin
                r_t[1][e] <= sext_val(w_in[9 + e]);
            end
            for (int k = 2; k <= ST_LEN; k++) begin
                r_m[k] <= r_m[k-1];
            end
            for (int k = 2; k <= ST_QB; k++) begin
                r_t[k] <= r_t[k-1];
            end

            for (int e = 0; e < 9; e++) begin
                r_p_sq[e] <= 64'(r_m[1][e] * r_m[1][e]);
            end
            r_p_cf[0] <= 64'(r_m[1][4] * r_m[1][8]);
            r_p_cf[1] <= 64'(r_m[1][7] * r_m[1][5]);
            r_p_cf[2] <= 64'(r_m[1][3] * r_m[1][8]);
            r_p_cf[3] <= 64'(r_m[1][5] * r_m[1][6]);
            r_p_cf[4] <= 64'(r_m[1][3] * r_m[1][7]);
            r_p_cf[5] <= 64'(r_m[1][4] * r_m[1][6]);

            for (int j = 0; j < 3; j++) begin
                r_cof[j] <= 65'(r_p_cf[2*j]) - 65'(r_p_cf[2*j+1]);
                r_sa[ST_COF][j].x <= r_p_sq[3*j] + r_p_sq[3*j+1] + r_p_sq[3*j+2];
                r_sa[ST_COF][j].r <= '0;
            end

            for (int j = 0; j < 3; j++) begin
                r_pl[j] <= 65'(r_m[ST_COF][j] * $signed({1'b0, r_cof[j][31:0]}));
                r_ph[j] <= 65'(r_m[ST_COF][j] * $signed(r_cof[j][64:32]));
                r_term[j] <= dat_pkg::det_term(r_ph[j], r_pl[j]);
            end
            r_neg[ST_DET] <= dat_pkg::det_negative(r_term[0], r_term[1], r_term[2]);
            for (int k = ST_DET + 1; k <= ST_LEN; k++) begin
                r_neg[k] <= r_neg[k-1];
            end

            for (int k = 0; k < dat_pkg::SQ_STEPS; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_sa[ST_COF+1+k][j] <= dat_pkg::sqrt_step(r_sa[ST_COF+k][j], k);
                end
            end

            for (int i = 0; i < 3; i++) begin
                r_da_len[ST_DA0][i] <= r_sa[ST_LEN][i].r[31:0];
                for (int j = 0; j < 3; j++) begin
                    r_da[ST_DA0][3*i+j].rem <= '0;
                    r_da[ST_DA0][3*i+j].dq  <= {dat_pkg::mag32(r_m[ST_LEN][3*i+j]), 30'd0};
                    r_da_neg[ST_DA0][3*i+j] <= r_m[ST_LEN][3*i+j][31] ^ r_neg[ST_LEN];
                end
            end
            r_scale[ST_DA0] <= scale_of(r_sa[ST_LEN][0].r[31:0], r_neg[ST_LEN]);
            for (int k = ST_DA0 + 1; k <= ST_QB; k++) begin
                r_scale[k] <= r_scale[k-1];
            end

            for (int k = 0; k < dat_pkg::DIVA_BITS; k++) begin
                r_da_len[ST_DA0+1+k] <= r_da_len[ST_DA0+k];
                r_da_neg[ST_DA0+1+k] <= r_da_neg[ST_DA0+k];
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        r_da[ST_DA0+1+k][3*i+j] <=
                            dat_pkg::diva_step(r_da[ST_DA0+k][3*i+j], r_da_len[ST_DA0+k][i]);
                    end
                end
            end

            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (r_da_len[ST_QA][i] == '0) begin
                        r_rm[3*i+j] <= '0;
                    end else if (r_da_neg[ST_QA][3*i+j]) begin
                        r_rm[3*i+j] <= -$signed({2'b00, r_da[ST_QA][3*i+j].dq});
                    end else begin
                        r_rm[3*i+j] <= $signed({2'b00, r_da[ST_QA][3*i+j].dq});
                    end
                end
            end

            r_tr        <= w_tr;
            r_qc[ST_TR] <= w_qc;
            r_x[ST_TR]  <= w_x;
            for (int k = ST_TR + 1; k <= ST_QB; k++) begin
                r_qc[k] <= r_qc[k-1];
            end
            for (int k = ST_TR + 1; k <= ST_S; k++) begin
                r_x[k] <= r_x[k-1];
            end

            r_pos[ST_SB0]  <= r_tr > 0;
            r_sb[ST_SB0].x <= {r_tr[33:0], 30'd0};
            r_sb[ST_SB0].r <= '0;
            for (int k = ST_SB0 + 1; k <= ST_QB; k++) begin
                r_pos[k] <= r_pos[k-1];
            end
            for (int k = 0; k < dat_pkg::SQ_STEPS; k++) begin
                r_sb[ST_SB0+1+k] <= dat_pkg::sqrt_step(r_sb[ST_SB0+k], k);
            end

            r_db_s[ST_DB0] <= r_sb[ST_S].r[31:0];
            r_main[ST_DB0] <= dat_pkg::main_of(r_sb[ST_S].r[31:0]);
            for (int j = 0; j < 3; j++) begin
                r_db[ST_DB0][j]     <= dat_pkg::divb_init(r_x[ST_S][j], r_sb[ST_S].r[31:0]);
                r_db_neg[ST_DB0][j] <= r_x[ST_S][j][63];
            end
            for (int k = 0; k < dat_pkg::DIVB_BITS; k++) begin
                r_db_s[ST_DB0+1+k]   <= r_db_s[ST_DB0+k];
                r_main[ST_DB0+1+k]   <= r_main[ST_DB0+k];
                r_db_neg[ST_DB0+1+k] <= r_db_neg[ST_DB0+k];
                for (int j = 0; j < 3; j++) begin
                    r_db[ST_DB0+1+k][j] <= dat_pkg::divb_step(r_db[ST_DB0+k][j],
                                                              r_db_s[ST_DB0+k]);
                end
            end
        end
    end

    // Saturation, sign and placement of the four quaternion components.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (r_db[ST_QB][j].sat || ({1'b0, r_db[ST_QB][j].dq} > dat_pkg::ONE_Q30)) begin
                w_cmp[j] = dat_pkg::ONE_Q30;
            end else begin
                w_cmp[j] = {1'b0, r_db[ST_QB][j].dq};
            end
            if (r_db_neg[ST_QB][j]) begin
                w_cmp[j] = -w_cmp[j];
            end
        end
        w_rot = '0;
        if (r_pos[ST_QB]) begin
            w_rot[r_qc[ST_QB]]         = {1'b0, r_main[ST_QB]};
            w_rot[r_qc[ST_QB] ^ 2'd1]  = w_cmp[0];
            w_rot[r_qc[ST_QB] ^ 2'd2]  = w_cmp[1];
            w_rot[r_qc[ST_QB] ^ 2'd3]  = w_cmp[2];
        end
        w_res.uniform_scale = r_scale[ST_QB];
        w_res.rot           = w_rot;
        w_res.move[0]       = r_t[ST_QB][0];
        w_res.move[1]       = r_t[ST_QB][1];
        w_res.move[2]       = r_t[ST_QB][2];
        w_res.degenerate    = !r_pos[ST_QB];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_sk_vld  <= 1'b0;
        end else if (r_sk_vld) begin
            if (i_out_ready) begin
                r_out    <= r_sk;
                r_sk_vld <= 1'b0;
            end
        end else if (r_vld[ST_QB]) begin
            if (!r_out_vld || i_out_ready) begin
                r_out     <= w_res;
                r_out_vld <= 1'b1;
            end else begin
                r_sk     <= w_res;
                r_sk_vld <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_uniform_scale = $signed(r_out.uniform_scale);
    assign o_rot_x         = $signed(r_out.rot[0]);
    assign o_rot_y         = $signed(r_out.rot[1]);
    assign o_rot_z         = $signed(r_out.rot[2]);
    assign o_rot_w         = $signed(r_out.rot[3]);
    assign o_move_x        = $signed(r_out.move[0]);
    assign o_move_y        = $signed(r_out.move[1]);
    assign o_move_z        = $signed(r_out.move[2]);
    assign o_degenerate    = r_out.degenerate;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_vld |-> r_out_vld)
        else $error("skid word held without an output word");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_vld) |-> $past(r_out_vld && !i_out_ready))
        else $error("skid filled while the output was free");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[1])
        else $error("accepted word did not enter the pipeline");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_degenerate) |->
            (o_rot_x == 0 && o_rot_y == 0 && o_rot_z == 0 && o_rot_w == 0))
        else $error("degenerate word carries a non-zero quaternion");

    a_rot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rot_x <= 32'sd1073741824 && o_rot_x >= -32'sd1073741824
                      && o_rot_w <= 32'sd1073741824 && o_rot_w >= -32'sd1073741824))
        else $error("quaternion component out of range");

endmodule

### tb/tb_decompose_affine_transform_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for decompose_affine_transform_unit: random and directed transforms
// pass through a valid/ready driver and monitor and are checked against an in-bench predictor.
// It depends on dat_pkg and the unit under test.
module tb_decompose_affine_transform_unit;

    typedef logic [11:0][31:0] t_xform;

    localparam int CYCLE_LIMIT = 600000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    logic signed [31:0] i_w [12] = '{default: '0};
    logic o_in_ready, o_out_valid, o_degenerate;
    logic signed [31:0] o_uniform_scale, o_rot_x, o_rot_y, o_rot_z, o_rot_w;
    logic signed [31:0] o_move_x, o_move_y, o_move_z;

    t_xform  pending_xforms[$];
    dat_pkg::t_result expected_poses[$];
    int      sender_idle_pct = 0;
    int      receiver_stall_pct = 0;
    bit      word_taken = 1'b0;
    int      mismatches = 0;
    int      checked = 0;
    int      degenerate_seen = 0;
    int      cycles = 0;

    decompose_affine_transform_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_basis0_x(i_w[0]), .i_basis0_y(i_w[1]), .i_basis0_z(i_w[2]),
        .i_basis1_x(i_w[3]), .i_basis1_y(i_w[4]), .i_basis1_z(i_w[5]),
        .i_basis2_x(i_w[6]), .i_basis2_y(i_w[7]), .i_basis2_z(i_w[8]),
        .i_offset_x(i_w[9]), .i_offset_y(i_w[10]), .i_offset_z(i_w[11]),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_uniform_scale(o_uniform_scale),
        .o_rot_x(o_rot_x), .o_rot_y(o_rot_y), .o_rot_z(o_rot_z), .o_rot_w(o_rot_w),
        .o_move_x(o_move_x), .o_move_y(o_move_y), .o_move_z(o_move_z),
        .o_degenerate(o_degenerate)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] r, b;
        r = '0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint side_term(input longint x, input logic [63:0] s);
        logic [63:0] q;
        q = (64'(x < 0 ? -x : x) << 29) / s;
        if (q > 64'd1073741824) q = 64'd1073741824;
        return x < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic dat_pkg::t_result predict_pose(input t_xform w);
        longint m[3][3];
        longint r[3][3];
        longint sg[3];
        longint tr, sc, mainc, xa, xb, xc;
        logic signed [127:0] c0, c1, c2, det;
        logic [63:0] sq, len, q, s;
        logic neg;
        int br;
        dat_pkg::t_result o;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) m[i][j] = longint'($signed(w[i * 3 + j]));
        c0 = 128'(m[1][1] * m[2][2]) - 128'(m[2][1] * m[1][2]);
        c1 = 128'(m[1][0] * m[2][2]) - 128'(m[1][2] * m[2][0]);
        c2 = 128'(m[1][0] * m[2][1]) - 128'(m[1][1] * m[2][0]);
        det = 128'(m[0][0]) * c0 - 128'(m[0][1]) * c1 + 128'(m[0][2]) * c2;
        neg = det[127];
        for (int i = 0; i < 3; i++) begin
            sq = '0;
            for (int j = 0; j < 3; j++) sq = sq + 64'(m[i][j] * m[i][j]);
            len = floor_root(sq);
            if (i == 0) sc = neg ? -longint'(len) : longint'(len);
            for (int j = 0; j < 3; j++) begin
                if (len == 0) begin
                    r[i][j] = 0;
                end else begin
                    q = (64'(m[i][j] < 0 ? -m[i][j] : m[i][j]) << 30) / len;
                    r[i][j] = ((m[i][j] < 0) != neg) ? -longint'(q) : longint'(q);
                end
            end
        end
        if (sc > 64'sd2147483647) sc = 64'sd2147483647;
        if (sc < -64'sd2147483648) sc = -64'sd2147483648;
        if (r[2][2] < 0) br = (r[0][0] > r[1][1]) ? dat_pkg::BR_X : dat_pkg::BR_Y;
        else br = (r[0][0] < -r[1][1]) ? dat_pkg::BR_Z : dat_pkg::BR_W;
        sg[0] = (br & 2) ? -1 : 1;
        sg[1] = (br & 1) ? -1 : 1;
        sg[2] = (br == dat_pkg::BR_X || br == dat_pkg::BR_W) ? -1 : 1;
        tr = 64'sd1073741824 - sg[2] * r[0][0] - sg[1] * r[1][1] - sg[0] * r[2][2];
        o.rot = '0;
        o.degenerate = (tr <= 0);
        if (tr > 0) begin
            s = floor_root(64'(tr) << 30);
            mainc = longint'(s >> 1);
            if (mainc > 1073741824) mainc = 1073741824;
            xa = side_term(r[0][1] + sg[0] * r[1][0], s);
            xb = side_term(r[2][0] + sg[1] * r[0][2], s);
            xc = side_term(r[1][2] + sg[2] * r[2][1], s);
            o.rot[br] = 32'(mainc);
            o.rot[br ^ 1] = 32'(xa);
            o.rot[br ^ 2] = 32'(xb);
            o.rot[br ^ 3] = 32'(xc);
        end
        o.uniform_scale = 32'(sc);
        o.move[0] = w[9];
        o.move[1] = w[10];
        o.move[2] = w[11];
        return o;
    endfunction

    function automatic logic [31:0] pick_value(input int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(262144, 0)) - 131072);
            2: return ($urandom_range(1, 0) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(64, 0)) - 32);
        endcase
    endfunction

    function automatic t_xform random_xform();
        t_xform w;
        int kind, p0, p1, p2;
        logic [31:0] mag;
        kind = $urandom_range(9, 0);
        for (int k = 0; k < 12; k++) w[k] = $urandom();
        if (kind < 5) begin
            p0 = $urandom_range(2, 0);
            p1 = (p0 + $urandom_range(2, 1)) % 3;
            p2 = 3 - p0 - p1;
            mag = 32'($urandom_range(1 << 22, 1));
            for (int k = 0; k < 9; k++) w[k] = pick_value(3);
            w[p0] = ($urandom_range(1, 0) != 0) ? mag : -mag;
            w[3 + p1] = ($urandom_range(1, 0) != 0) ? mag : -mag;
            w[6 + p2] = ($urandom_range(1, 0) != 0) ? mag : -mag;
        end else if (kind < 8) begin
            for (int k = 0; k < 9; k++) w[k] = pick_value(kind - 5);
            if ($urandom_range(7, 0) == 0) begin
                p0 = $urandom_range(2, 0);
                w[p0 * 3] = '0;
                w[p0 * 3 + 1] = '0;
                w[p0 * 3 + 2] = '0;
            end
        end else begin
            for (int k = 0; k < 12; k++) w[k] = pick_value($urandom_range(3, 0));
        end
        return w;
    endfunction

    function automatic t_xform diag_xform(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] t);
        t_xform w;
        w = '0;
        w[0] = a;
        w[4] = b;
        w[8] = c;
        w[9] = t;
        w[10] = ~t;
        w[11] = t ^ 32'h5a5a_5a5a;
        return w;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch on result %0d, %s: got %h, expected %h", checked, field, got, want);
    endtask

    always @(posedge i_clk) begin
        t_xform  w;
        dat_pkg::t_result want;
        logic [8:0][31:0] got_f, want_f;
        string names[9];
        names = '{"uniform_scale", "rot_x", "rot_y", "rot_z", "rot_w",
                  "move_x", "move_y", "move_z", "degenerate"};
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            for (int k = 0; k < 12; k++) w[k] = i_w[k];
            expected_poses.push_back(predict_pose(w));
            word_taken = 1'b1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_poses.size() == 0) begin
                report_mismatch("unexpected word", 32'(o_uniform_scale), '0);
            end else begin
                want = expected_poses.pop_front();
                got_f = {32'(o_degenerate), o_move_z, o_move_y, o_move_x,
                         o_rot_w, o_rot_z, o_rot_y, o_rot_x, o_uniform_scale};
                want_f = {32'(want.degenerate), want.move[2], want.move[1], want.move[0],
                          want.rot[3], want.rot[2], want.rot[1], want.rot[0],
                          want.uniform_scale};
                for (int k = 0; k < 9; k++)
                    if (got_f[k] !== want_f[k]) report_mismatch(names[k], got_f[k], want_f[k]);
                if (want.degenerate) degenerate_seen++;
            end
            checked++;
        end
    end

    always @(negedge i_clk) begin
        t_xform w;
        logic next_valid;
        next_valid = i_in_valid;
        if (i_in_valid && word_taken) begin
            next_valid = 1'b0;
            word_taken = 1'b0;
        end
        if (!next_valid && i_rst_n && pending_xforms.size() != 0 &&
            $urandom_range(99, 0) >= sender_idle_pct) begin
            w = pending_xforms.pop_front();
            for (int k = 0; k < 12; k++) i_w[k] <= w[k];
            next_valid = 1'b1;
        end
        i_in_valid <= next_valid;
        i_out_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
    end

    task automatic drain();
        while (pending_xforms.size() != 0 || i_in_valid || expected_poses.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int idle_set[4];
        int stall_set[4];
        idle_set = '{0, 79, 0, 15};
        stall_set = '{0, 0, 79, 15};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        pending_xforms.push_back(diag_xform('0, '0, '0, '0));
        pending_xforms.push_back(diag_xform(32'h10000, 32'h10000, 32'h10000, 32'h7fff_ffff));
        pending_xforms.push_back(diag_xform(32'hffff0000, 32'hffff0000, 32'hffff0000,
                                            32'h8000_0000));
        pending_xforms.push_back(diag_xform(32'h10000, 32'hffff0000, 32'hffff0000, 32'h1));
        pending_xforms.push_back(diag_xform(32'hffff0000, 32'h10000, 32'hffff0000, 32'h2));
        pending_xforms.push_back(diag_xform(32'hffff0000, 32'hffff0000, 32'h10000, 32'h3));
        pending_xforms.push_back(diag_xform(32'h10000, 32'h10000, '0, 32'h4));
        pending_xforms.push_back(diag_xform('0, 32'h10000, 32'h10000, 32'h5));
        pending_xforms.push_back(diag_xform(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, '1));
        pending_xforms.push_back(diag_xform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0));
        pending_xforms.push_back('1);
        pending_xforms.push_back({12{32'h8000_0000}});
        pending_xforms.push_back({12{32'h7fff_ffff}});
        pending_xforms.push_back({32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0,
                                  32'h0, 32'hffff0000, 32'h0, 32'h10000, 32'h0, 32'h0});
        for (int k = 0; k < 6; k++) begin
            t_xform w;
            w = '0;
            w[(k % 3) * 4 - (k % 3) * 1] = 32'h10000;
            w[3 * ((k + 1) % 3) + (k % 3)] = (k < 3) ? 32'h10000 : 32'hffff0000;
            w[3 * ((k + 2) % 3) + ((k + 1) % 3)] = 32'h10000;
            pending_xforms.push_back(w);
        end
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = idle_set[ph];
            receiver_stall_pct = stall_set[ph];
            for (int k = 0; k < 290; k++) pending_xforms.push_back(random_xform());
            drain();
        end
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (200) @(posedge i_clk);
        $display("Checked %0d decompositions (%0d degenerate) over four idling phases,",
                 checked, degenerate_seen);
        $display("with %0d mismatching fields.", mismatches);
        if (mismatches == 0 && expected_poses.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

### filelist.f
hw/rtl/dat_pkg.sv
hw/rtl/decompose_affine_transform_unit.sv
tb/tb_decompose_affine_transform_unit.sv
